// ===== sv/psba_pkg.sv =====
// Package for the partial-sum bias accumulator.
// It holds the lane geometry, the command and register codes and the transaction types.
// It has no dependencies.
package psba_pkg;

  localparam int LANES      = 4;
  localparam int LANE_BITS  = 32;
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_PASSES = 256;

  localparam int DIM_CFG_W  = 7;
  localparam int ITER_CFG_W = 9;
  localparam int PASS_W     = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [0:0] {
    CMD_BIAS  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEIGHT = 8'd0,
    CFG_WIDTH  = 8'd1,
    CFG_ITERS  = 8'd2
  } cfg_reg_e;

  typedef logic [LANES-1:0][LANE_BITS-1:0] lanes_t;

  typedef struct packed {
    cmd_e               command;
    logic signed [31:0] value_0;
    logic signed [31:0] value_1;
    logic signed [31:0] value_2;
    logic signed [31:0] value_3;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sum_0;
    logic signed [31:0] sum_1;
    logic signed [31:0] sum_2;
    logic signed [31:0] sum_3;
    logic               frame_end;
  } out_item_t;

endpackage

// ===== sv/psba_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// The read data holds while the read enable is low. It has no dependencies.
module psba_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [DATA_W-1:0]                     wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [DATA_W-1:0]                     rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/partial_sum_bias_accumulator.sv =====
// Top level of the partial-sum bias accumulator.
// It depends on psba_pkg and on the generic RAM psba_ram.
//
// The block takes one transaction per cycle on the input channel when not stalled. Each result
// passes the stage-1 and output registers; the per-pixel sum store is read at acceptance and
// written back as stage 1 fires, with a forwarding path when the same pixel follows directly.
// The input stalls only while a result waits in the output register and the output is stalled.
// A bias transaction latches the lane biases and restarts the frame; it produces no result.
// A register write applies to every transaction accepted after it.
module partial_sum_bias_accumulator #(
  parameter int MAX_WIDTH  = psba_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = psba_pkg::MAX_HEIGHT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  psba_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output psba_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [psba_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [psba_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int NW     = $clog2(PIXELS + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int PW     = psba_pkg::ITER_CFG_W;
  localparam int DW     = psba_pkg::LANES * psba_pkg::LANE_BITS;

  logic [psba_pkg::DIM_CFG_W-1:0]  height_q, width_q;
  logic [psba_pkg::ITER_CFG_W-1:0] iters_q;
  logic [NW-1:0]                   npix;
  logic [PW-1:0]                   passes;
  logic [HW-1:0]                   h_cl;
  logic [WW-1:0]                   w_cl;

  psba_pkg::lanes_t bias_q, in_lanes, base, sum, fwd_q, rdata;
  logic [AW-1:0]                   pos_q, pos_d;
  logic [psba_pkg::PASS_W-1:0]     pass_q, pass_d;

  logic             s1_valid_q, s1_valid_d;
  logic [AW-1:0]    s1_pos_q;
  logic             s1_first_q, s1_fwd_q, s1_last_pass_q, s1_last_pix_q;
  psba_pkg::lanes_t s1_val_q, s1_bias_q;

  logic                out_valid_q, out_valid_d;
  psba_pkg::out_item_t out_q;

  logic in_acc, pix_acc, bias_acc, s1_fire, adv, out_free;
  logic first, last_pass, last_pix, hit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= psba_pkg::DIM_CFG_W'(1);
      width_q  <= psba_pkg::DIM_CFG_W'(1);
      iters_q  <= psba_pkg::ITER_CFG_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        psba_pkg::CFG_HEIGHT: height_q <= cfg_data_i[psba_pkg::DIM_CFG_W-1:0];
        psba_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[psba_pkg::DIM_CFG_W-1:0];
        psba_pkg::CFG_ITERS:  iters_q  <= cfg_data_i[psba_pkg::ITER_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (height_q == '0) begin
      h_cl = HW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_cl = HW'(MAX_HEIGHT);
    end else begin
      h_cl = HW'(height_q);
    end
    if (width_q == '0) begin
      w_cl = WW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_cl = WW'(MAX_WIDTH);
    end else begin
      w_cl = WW'(width_q);
    end
    if (iters_q == '0) begin
      passes = PW'(1);
    end else if (32'(iters_q) > 32'(psba_pkg::MAX_PASSES)) begin
      passes = PW'(psba_pkg::MAX_PASSES);
    end else begin
      passes = iters_q;
    end
    npix = NW'((HW + WW)'(h_cl) * (HW + WW)'(w_cl));
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!s1_last_pass_q || out_free);
  assign adv        = !s1_valid_q || s1_fire;
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pix_acc    = in_acc && (in_item_i.command == psba_pkg::CMD_PIXEL);
  assign bias_acc   = in_acc && (in_item_i.command == psba_pkg::CMD_BIAS);

  assign in_lanes = {in_item_i.value_3, in_item_i.value_2, in_item_i.value_1, in_item_i.value_0};

  assign first     = (pass_q == '0);
  assign last_pass = ((PW + 1)'(pass_q) + (PW + 1)'(1)) >= (PW + 1)'(passes);
  assign last_pix  = ((NW + 1)'(pos_q) + (NW + 1)'(1)) >= (NW + 1)'(npix);
  assign hit       = s1_valid_q && (s1_pos_q == pos_q);

  always_comb begin
    pos_d  = pos_q;
    pass_d = pass_q;
    if (bias_acc) begin
      pos_d  = '0;
      pass_d = '0;
    end else if (pix_acc) begin
      if (last_pix) begin
        pos_d  = '0;
        pass_d = last_pass ? '0 : pass_q + psba_pkg::PASS_W'(1);
      end else begin
        pos_d = pos_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      pass_q <= '0;
      bias_q <= '0;
    end else begin
      pos_q  <= pos_d;
      pass_q <= pass_d;
      if (bias_acc) begin
        bias_q <= in_lanes;
      end
    end
  end

  assign s1_valid_d = pix_acc || (s1_valid_q && !s1_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_pos_q       <= pos_q;
      s1_first_q     <= first;
      s1_fwd_q       <= hit;
      s1_last_pass_q <= last_pass;
      s1_last_pix_q  <= last_pix;
      s1_val_q       <= in_lanes;
      s1_bias_q      <= bias_q;
    end
    if (s1_fire) begin
      fwd_q <= sum;
    end
  end

  psba_ram #(
    .DATA_W (DW),
    .DEPTH  (PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_pos_q),
    .wdata_i (sum),
    .re_i    (pix_acc),
    .raddr_i (pos_q),
    .rdata_o (rdata)
  );

  always_comb begin
    if (s1_first_q) begin
      base = s1_bias_q;
    end else if (s1_fwd_q) begin
      base = fwd_q;
    end else begin
      base = rdata;
    end
    for (int l = 0; l < psba_pkg::LANES; l++) begin
      sum[l] = base[l] + s1_val_q[l];
    end
  end

  assign out_valid_d = (s1_fire && s1_last_pass_q) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_pass_q) begin
      out_q.sum_0     <= sum[0];
      out_q.sum_1     <= sum[1];
      out_q.sum_2     <= sum[2];
      out_q.sum_3     <= sum[3];
      out_q.frame_end <= s1_last_pix_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_bias_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bias_acc |=> (pos_q == '0) && (pass_q == '0))
    else $error("Bias transaction did not restart the frame counters.");

  a_emit_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_pass_q) |=> out_valid_q)
    else $error("Final-pass sum did not reach the output register.");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("Pending result dropped while the output was stalled.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_last_pass_q && out_valid_q && out_stall_i))
    else $error("Input stalled without a blocked result.");
`endif

endmodule

// ===== dv/tb_partial_sum_bias_accumulator.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for partial_sum_bias_accumulator, with its own accumulator model.
// It depends on psba_pkg and on the RTL of the block; it reads no files.
module tb_partial_sum_bias_accumulator;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 190;
  localparam int PIXELS        = psba_pkg::MAX_WIDTH * psba_pkg::MAX_HEIGHT;

  typedef struct {
    psba_pkg::in_item_t  item;
    bit                  typed;
    psba_pkg::out_item_t res;
  } vector_t;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  psba_pkg::in_item_t              in_item   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  psba_pkg::out_item_t             out_item;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [psba_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [psba_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic [psba_pkg::LANE_BITS-1:0]  bias_reg [psba_pkg::LANES];
  logic [psba_pkg::LANE_BITS-1:0]  pixel_sums [PIXELS][psba_pkg::LANES];
  bit                              pixel_written [PIXELS];
  logic [11:0]                     pix_pos;
  logic [psba_pkg::PASS_W-1:0]     pass_idx;
  logic [psba_pkg::DIM_CFG_W-1:0]  rows_cfg;
  logic [psba_pkg::DIM_CFG_W-1:0]  cols_cfg;
  logic [psba_pkg::ITER_CFG_W-1:0] iters_cfg;

  psba_pkg::out_item_t expected_sums[$];
  psba_pkg::out_item_t exp_res;
  vector_t             directed_vectors[$];
  int                  idle_mode = 1;
  int                  stall_left = 0;
  int                  error_count = 0;
  int                  item_count = 0;
  int                  cycle_count = 0;

  partial_sum_bias_accumulator u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int gap_len(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) begin
      return 0;
    end
    if (mode == 1) begin
      if (r < 80) return 0;
      if (r < 98) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(8, 30);
  endfunction

  function automatic int clamp_cfg(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [31:0] rand_lane();
    case ($urandom_range(0, 11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] reg_word(int v, int bits);
    logic [31:0] junk;
    junk = $urandom;
    if ($urandom_range(0, 2) == 0) return (junk << bits) | v;
    return v;
  endfunction

  // Model of one accepted transaction; returns 1 when the pixel yields a result.
  function automatic bit accumulate_pixel(input psba_pkg::in_item_t item,
                                          output psba_pkg::out_item_t res);
    logic [psba_pkg::LANE_BITS-1:0] lane_in [psba_pkg::LANES];
    logic [psba_pkg::LANE_BITS-1:0] lane_sum [psba_pkg::LANES];
    int npix;
    int passes;
    bit first;
    bit last_pass;
    bit last_pixel;
    lane_in[0] = item.value_0;
    lane_in[1] = item.value_1;
    lane_in[2] = item.value_2;
    lane_in[3] = item.value_3;
    res = '0;
    if (item.command == psba_pkg::CMD_BIAS) begin
      bias_reg = lane_in;
      pix_pos  = '0;
      pass_idx = '0;
      return 1'b0;
    end
    npix       = clamp_cfg(rows_cfg, psba_pkg::MAX_HEIGHT)
                 * clamp_cfg(cols_cfg, psba_pkg::MAX_WIDTH);
    passes     = clamp_cfg(iters_cfg, psba_pkg::MAX_PASSES);
    first      = (pass_idx == 0);
    last_pass  = (int'(pass_idx) + 1 >= passes);
    last_pixel = (int'(pix_pos) + 1 >= npix);
    for (int l = 0; l < psba_pkg::LANES; l++) begin
      lane_sum[l] = (first ? bias_reg[l] : pixel_sums[pix_pos][l]) + lane_in[l];
      pixel_sums[pix_pos][l] = lane_sum[l];
    end
    pixel_written[pix_pos] = 1'b1;
    res.sum_0     = lane_sum[0];
    res.sum_1     = lane_sum[1];
    res.sum_2     = lane_sum[2];
    res.sum_3     = lane_sum[3];
    res.frame_end = last_pixel;
    if (last_pixel) begin
      pix_pos  = '0;
      pass_idx = last_pass ? '0 : pass_idx + 1'b1;
    end else begin
      pix_pos = pix_pos + 1'b1;
    end
    return last_pass;
  endfunction

  function automatic vector_t make_vector(psba_pkg::cmd_e cmd, logic [31:0] a,
                                          logic [31:0] b, logic [31:0] c,
                                          logic [31:0] d, bit typed,
                                          logic [31:0] s0, logic [31:0] s1,
                                          logic [31:0] s2, logic [31:0] s3);
    vector_t v;
    v.item.command = cmd;
    v.item.value_0 = a;
    v.item.value_1 = b;
    v.item.value_2 = c;
    v.item.value_3 = d;
    v.typed        = typed;
    v.res.sum_0    = s0;
    v.res.sum_1    = s1;
    v.res.sum_2    = s2;
    v.res.sum_3    = s3;
    v.res.frame_end = typed;
    return v;
  endfunction

  task automatic send_item(input psba_pkg::in_item_t item, input bit typed_ok,
                           input psba_pkg::out_item_t typed_res);
    int gap;
    psba_pkg::out_item_t res;
    gap = gap_len(idle_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (in_stall);
    if (accumulate_pixel(item, res)) begin
      expected_sums.push_back(typed_ok ? typed_res : res);
    end
    item_count++;
  endtask

  task automatic send_bias();
    psba_pkg::in_item_t item;
    item.command = psba_pkg::CMD_BIAS;
    item.value_0 = rand_lane();
    item.value_1 = rand_lane();
    item.value_2 = rand_lane();
    item.value_3 = rand_lane();
    send_item(item, 1'b0, '0);
  endtask

  // A later pass must never read a pixel sum that was not stored since reset.
  task automatic send_pixel();
    psba_pkg::in_item_t item;
    if (pass_idx != 0 && !pixel_written[pix_pos]) begin
      send_bias();
    end
    item.command = psba_pkg::CMD_PIXEL;
    item.value_0 = rand_lane();
    item.value_1 = rand_lane();
    item.value_2 = rand_lane();
    item.value_3 = rand_lane();
    send_item(item, 1'b0, '0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_sums.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [psba_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psba_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      psba_pkg::CFG_HEIGHT: rows_cfg  = data[psba_pkg::DIM_CFG_W-1:0];
      psba_pkg::CFG_WIDTH:  cols_cfg  = data[psba_pkg::DIM_CFG_W-1:0];
      psba_pkg::CFG_ITERS:  iters_cfg = data[psba_pkg::ITER_CFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_registers(int h, int w, int it);
    wait_idle();
    if ($urandom_range(0, 3) == 0) begin
      write_reg(psba_pkg::CFG_IDX_W'($urandom_range(psba_pkg::CFG_ITERS + 1, 255)),
                $urandom);
    end
    write_reg(psba_pkg::CFG_HEIGHT, reg_word(h, psba_pkg::DIM_CFG_W));
    write_reg(psba_pkg::CFG_WIDTH, reg_word(w, psba_pkg::DIM_CFG_W));
    write_reg(psba_pkg::CFG_ITERS, reg_word(it, psba_pkg::ITER_CFG_W));
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = gap_len(idle_mode);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        $display("%0t: result transaction %h arrived with none expected", $time, out_item);
        error_count++;
      end else begin
        exp_res = expected_sums.pop_front();
        check_field("sum_0", exp_res.sum_0, out_item.sum_0);
        check_field("sum_1", exp_res.sum_1, out_item.sum_1);
        check_field("sum_2", exp_res.sum_2, out_item.sum_2);
        check_field("sum_3", exp_res.sum_3, out_item.sum_3);
        check_field("frame_end", 32'(exp_res.frame_end), 32'(out_item.frame_end));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int h;
    int w;
    int it;
    int frames;
    int total;
    int random_start;
    bias_reg  = '{default: '0};
    pix_pos   = '0;
    pass_idx  = '0;
    rows_cfg  = 1;
    cols_cfg  = 1;
    iters_cfg = 1;

    // One pixel per frame after reset, so every pixel produces a sum.
    directed_vectors.push_back(make_vector(psba_pkg::CMD_PIXEL, 32'h0, 32'h0, 32'h0, 32'h0,
                                           1'b1, 32'h0, 32'h0, 32'h0, 32'h0));
    directed_vectors.push_back(make_vector(psba_pkg::CMD_PIXEL, 32'h7FFF_FFFF, 32'h8000_0000,
                                           32'hFFFF_FFFF, 32'h0000_0001, 1'b1,
                                           32'h7FFF_FFFF, 32'h8000_0000,
                                           32'hFFFF_FFFF, 32'h0000_0001));
    directed_vectors.push_back(make_vector(psba_pkg::CMD_BIAS, 32'h1, 32'h1, 32'h1,
                                           32'hFFFF_FFFF,
                                           1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
    directed_vectors.push_back(make_vector(psba_pkg::CMD_PIXEL, 32'h7FFF_FFFF, 32'h8000_0000,
                                           32'hFFFF_FFFF, 32'h0000_0001, 1'b1,
                                           32'h8000_0000, 32'h8000_0001, 32'h0, 32'h0));
    directed_vectors.push_back(make_vector(psba_pkg::CMD_PIXEL, 32'h0, 32'h0, 32'h0, 32'h0,
                                           1'b1, 32'h1, 32'h1, 32'h1, 32'hFFFF_FFFF));
    directed_vectors.push_back(make_vector(psba_pkg::CMD_BIAS, 32'h8000_0000, 32'h8000_0000,
                                           32'h8000_0000, 32'h8000_0000,
                                           1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
    directed_vectors.push_back(make_vector(psba_pkg::CMD_BIAS, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                           32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                           1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
    directed_vectors.push_back(make_vector(psba_pkg::CMD_PIXEL, 32'h7FFF_FFFF, 32'h8000_0000,
                                           32'hFFFF_FFFF, 32'h0000_0001, 1'b1,
                                           32'hFFFF_FFFE, 32'hFFFF_FFFF,
                                           32'hFFFF_FFFE, 32'h0000_0000));
    directed_vectors.push_back(make_vector(psba_pkg::CMD_BIAS, 32'h8000_0000, 32'h8000_0000,
                                           32'h8000_0000, 32'h8000_0000,
                                           1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
    directed_vectors.push_back(make_vector(psba_pkg::CMD_PIXEL, 32'h8000_0000, 32'h8000_0000,
                                           32'h8000_0000, 32'h8000_0000,
                                           1'b1, 32'h0, 32'h0, 32'h0, 32'h0));
    directed_vectors.push_back(make_vector(psba_pkg::CMD_BIAS, 32'h5555_5555, 32'hAAAA_AAAA,
                                           32'hF0F0_F0F0, 32'h0F0F_0F0F,
                                           1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
    directed_vectors.push_back(make_vector(psba_pkg::CMD_PIXEL, 32'hAAAA_AAAA, 32'h5555_5555,
                                           32'h0F0F_0F0F, 32'hF0F0_F0F0,
                                           1'b0, 32'h0, 32'h0, 32'h0, 32'h0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_vectors[i]) begin
      send_item(directed_vectors[i].item, directed_vectors[i].typed, directed_vectors[i].res);
    end

    program_registers(0, 0, 0);
    send_bias();
    repeat (3) send_pixel();

    // Multi-pass frame, then the geometry shrinks in the middle of a later pass.
    idle_mode = 2;
    program_registers(2, 3, 3);
    send_bias();
    repeat (26) send_pixel();
    program_registers(1, 2, 2);
    repeat (5) send_pixel();

    idle_mode = 1;
    program_registers(127, 1, 1);
    repeat (psba_pkg::MAX_HEIGHT) send_pixel();
    program_registers(1, 1, 511);
    send_bias();
    repeat (8) send_pixel();
    program_registers(2, 1, psba_pkg::MAX_PASSES);
    repeat (8) send_pixel();
    program_registers(psba_pkg::MAX_HEIGHT, 1, 2);
    send_bias();
    repeat (2 * psba_pkg::MAX_HEIGHT) send_pixel();

    random_start = item_count;
    while (item_count - random_start < RANDOM_ITEMS) begin
      h  = $urandom_range(0, 4);
      w  = $urandom_range(0, 4);
      it = $urandom_range(0, 4);
      case ($urandom_range(0, 9))
        0: begin
          h  = $urandom_range(5, 127);
          w  = 1;
          it = $urandom_range(0, 2);
        end
        1: begin
          w  = $urandom_range(5, 127);
          h  = $urandom_range(0, 1);
          it = $urandom_range(0, 2);
        end
        2: begin
          h  = 1;
          w  = $urandom_range(0, 1);
          it = $urandom_range(5, 511);
        end
        default: ;
      endcase
      program_registers(h, w, it);
      idle_mode = $urandom_range(0, 2);
      frames = $urandom_range(1, 3);
      total  = frames * clamp_cfg(rows_cfg, psba_pkg::MAX_HEIGHT)
               * clamp_cfg(cols_cfg, psba_pkg::MAX_WIDTH)
               * clamp_cfg(iters_cfg, psba_pkg::MAX_PASSES);
      if ($urandom_range(0, 4) == 0) begin
        total = $urandom_range(1, total);
      end
      for (int k = 0; k < total && item_count - random_start < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 99) == 0) begin
          wait_idle();
        end
        if ((pix_pos == 0 && pass_idx == 0 && $urandom_range(0, 3) != 0)
            || $urandom_range(0, 59) == 0) begin
          send_bias();
        end
        send_pixel();
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
